// ===== rtl/bpfa_pkg.sv =====
// shared types and constants of the bitmap page frame allocator
package bpfa_pkg;

  localparam int ADDR_W     = 32;
  localparam int REGION_W   = 40;
  localparam int COUNT_W    = 17;
  localparam int PAGE_SHIFT = 12;
  localparam logic [PAGE_SHIFT-1:0] PAGE_OFFSET_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // width of a frame number taken from a region byte address
  localparam int REGION_FRAME_W = REGION_W + 1 - PAGE_SHIFT;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_REGION = 2'd1,
    KIND_ALLOC  = 2'd2,
    KIND_FREE   = 2'd3
  } kind_t;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_DONE     = 2'd0;
  localparam status_t STATUS_NO_FRAME = 2'd1;
  localparam status_t STATUS_IGNORED  = 2'd2;

endpackage

// ===== rtl/bitmap_page_frame_allocator.sv =====
// next-fit bitmap page frame allocator with the occupancy bitmap held in one memory
//
// One occupancy bit per 4 KiB frame (1 = occupied) lives in a single memory of
// FRAME_COUNT/WORD_BITS words, rounded up, read through a register and written
// back after each word is examined. Every item gives exactly one result. After
// reset the block sweeps the memory to all ones, one word a cycle, through all
// WORD_COUNT words (2048 with the default parameters) and takes no item
// meanwhile; the kernel end register can still be written. A clear item runs
// the same sweep before its result. Region, allocate and free items share one
// word walker: a set-up of range clipping, a reciprocal multiply that turns the
// first frame into a word index, and the word base, and then for each bitmap
// word a read state and an evaluate state, as the word is read into a register
// in the one and written back in the other. A failing allocate walks every word
// between the kernel end frame and FRAME_COUNT, unless the free count is zero,
// when it fails without a walk. A free item examines a single word. Results sit
// in an output register, so the next item is taken as soon as a result has
// been placed there, whether or not it has been collected yet.
module bitmap_page_frame_allocator #(
  parameter int FRAME_COUNT = 65536,
  parameter int WORD_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [bpfa_pkg::ADDR_W-1:0]           cfg_wdata,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            kind,
  input  logic [bpfa_pkg::REGION_W-1:0]         region_base,
  input  logic [bpfa_pkg::REGION_W-1:0]         region_length,
  input  logic                                  region_available,
  input  logic [bpfa_pkg::ADDR_W-1:0]           page_addr,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [bpfa_pkg::ADDR_W-1:0]           alloc_addr,
  output logic [bpfa_pkg::COUNT_W-1:0]          free_pages,
  output logic [bpfa_pkg::COUNT_W-1:0]          total_pages
);

  localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int HINT_W     = $clog2(FRAME_COUNT + 1);
  localparam int CNT_W      = $clog2(FRAME_COUNT + 1);
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int RW         = bpfa_pkg::REGION_FRAME_W;
  localparam int KF_W       = bpfa_pkg::ADDR_W + 1 - bpfa_pkg::PAGE_SHIFT;
  // frame / WORD_BITS as a multiply by a rounded-up reciprocal, exact below 2**HINT_W
  localparam int SHIFT      = HINT_W + OFF_W;
  localparam int PW         = 2 * HINT_W + 1;
  localparam logic [HINT_W:0] RECIP =
    (HINT_W+1)'(((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [HINT_W-1:0] WB_F  = HINT_W'(WORD_BITS);
  localparam logic [OFF_W:0]    WB_O  = (OFF_W+1)'(WORD_BITS);
  localparam logic [HINT_W-1:0] FC_H  = HINT_W'(FRAME_COUNT);
  localparam logic [RW-1:0]     FC_R  = RW'(FRAME_COUNT);
  localparam logic [AW-1:0]     LAST_W = AW'(WORD_COUNT - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_RANGE = 9'b000000100,
    S_DIVQ  = 9'b000001000,
    S_DIVB  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_CLR   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;

  // configuration and derived kernel end frame
  logic [bpfa_pkg::ADDR_W-1:0] kernel_end;
  logic [HINT_W-1:0]           kend_frame;
  logic [bpfa_pkg::ADDR_W:0]   kend_round;
  logic [KF_W-1:0]             kend_raw;

  // latched request
  bpfa_pkg::kind_t               op;
  logic [bpfa_pkg::REGION_W-1:0] req_base;
  logic [bpfa_pkg::REGION_W-1:0] req_len;
  logic                          req_avail;
  logic [bpfa_pkg::ADDR_W-1:0]   req_page;

  // allocator state outside the bitmap
  logic [CNT_W-1:0]            free_count;
  logic [bpfa_pkg::COUNT_W-1:0] total_count;
  logic [HINT_W-1:0]           search_hint;

  // range set-up
  logic [RW-1:0] rng_lo;
  logic [RW-1:0] rng_hi;
  logic          rng_ok;
  logic          first_pass;

  // word walker
  logic [HINT_W-1:0] cur_lo;
  logic [HINT_W-1:0] cur_hi;
  logic [AW-1:0]     cur_w;
  logic [HINT_W-1:0] cur_base;
  logic [OFF_W-1:0]  lo_off;
  logic [OFF_W:0]    hi_off;
  logic              more;

  // clearing sweep
  logic [AW-1:0] clr_w;
  logic          clr_report;

  // pending result
  bpfa_pkg::status_t           res_status;
  logic [bpfa_pkg::ADDR_W-1:0] res_addr;

  // bitmap memory
  logic [WORD_BITS-1:0] bitmap [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  assign in_ready = (state == S_IDLE);

  // kernel end rounded up to a frame; kend_frame caps it at the frame range
  assign kend_round = {1'b0, kernel_end} + (bpfa_pkg::ADDR_W+1)'(bpfa_pkg::PAGE_OFFSET_MAX);
  assign kend_raw   = kend_round[bpfa_pkg::ADDR_W:bpfa_pkg::PAGE_SHIFT];

  // region clipping: start at or above kernel end, rounded up; end rounded down and capped
  logic [bpfa_pkg::REGION_W:0]   end_sum;
  logic                          end_above;
  logic [bpfa_pkg::REGION_W-1:0] start_clip;
  logic [bpfa_pkg::REGION_W:0]   start_round;
  logic [RW-1:0]                 reg_sf;
  logic [RW-1:0]                 ef_raw;
  logic [RW-1:0]                 reg_ef;

  assign end_sum     = {1'b0, req_base} + {1'b0, req_len};
  assign end_above   = end_sum > (bpfa_pkg::REGION_W+1)'(kernel_end);
  assign start_clip  = (req_base < bpfa_pkg::REGION_W'(kernel_end)) ?
                       bpfa_pkg::REGION_W'(kernel_end) : req_base;
  assign start_round = {1'b0, start_clip} +
                       (bpfa_pkg::REGION_W+1)'(bpfa_pkg::PAGE_OFFSET_MAX);
  assign reg_sf      = start_round[bpfa_pkg::REGION_W:bpfa_pkg::PAGE_SHIFT];
  assign ef_raw      = end_sum[bpfa_pkg::REGION_W:bpfa_pkg::PAGE_SHIFT];
  assign reg_ef      = (ef_raw > FC_R) ? FC_R : ef_raw;

  // free request checks
  logic [KF_W-2:0] free_f;
  logic            free_ok;

  assign free_f  = req_page[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
  assign free_ok = (req_page != '0) &&
                   (req_page[bpfa_pkg::PAGE_SHIFT-1:0] == '0) &&
                   ({12'b0, free_f} >= 32'(kend_frame)) &&
                   ({12'b0, free_f} < 32'(FRAME_COUNT));

  // word index by reciprocal multiply, then the word's first frame
  logic [PW-1:0]     div_prod;
  logic [HINT_W-1:0] word_base;
  logic [HINT_W-1:0] diff_hi;

  assign div_prod  = PW'(cur_lo) * PW'(RECIP);
  assign word_base = HINT_W'(HINT_W'(cur_w) * WB_F);
  assign diff_hi   = cur_hi - cur_base;

  // word evaluation
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hit;
  logic [WORD_BITS-1:0] cand;
  logic [OFF_W-1:0]     idx;
  logic [CNT_W-1:0]     hit_cnt;
  logic [bpfa_pkg::COUNT_W:0] total_sum;
  logic [HINT_W-1:0]    found_frame;
  logic                 eval_write;
  logic [WORD_BITS-1:0] eval_wd;
  logic                 eval_take;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = ((OFF_W+1)'(i) >= {1'b0, lo_off}) && ((OFF_W+1)'(i) < hi_off);
    end
  end

  assign hit  = rd_data & mask;
  assign cand = ~rd_data & mask;

  // lowest free frame in range
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = OFF_W'(i);
      end
    end
  end

  assign hit_cnt     = CNT_W'($countones(hit));
  assign total_sum   = {1'b0, total_count} + (bpfa_pkg::COUNT_W+1)'(hit_cnt);
  assign found_frame = cur_base + HINT_W'(idx);
  assign eval_take   = (state == S_EVAL) && (op == bpfa_pkg::KIND_ALLOC) && (cand != '0);

  always_comb begin
    eval_write = 1'b0;
    eval_wd    = rd_data & ~mask;
    case (op)
      bpfa_pkg::KIND_REGION: eval_write = 1'b1;
      bpfa_pkg::KIND_ALLOC: begin
        eval_write = (cand != '0);
        eval_wd    = rd_data | (WORD_BITS'(1) << idx);
      end
      bpfa_pkg::KIND_FREE:  eval_write = (hit != '0);
      default:              eval_write = 1'b0;
    endcase
  end

  assign mem_we = (state == S_CLR) || ((state == S_EVAL) && eval_write);
  assign mem_wa = (state == S_CLR) ? clr_w : cur_w;
  assign mem_wd = (state == S_CLR) ? '1 : eval_wd;

  // bitmap: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_wa] <= mem_wd;
    end
    if (state == S_READ) begin
      rd_data <= bitmap[cur_w];
    end
  end

  // configuration register and its frame form
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end <= '0;
    end else if (cfg_we) begin
      kernel_end <= cfg_wdata;
    end
    kend_frame <= ({11'b0, kend_raw} > 32'(FRAME_COUNT)) ? FC_H : HINT_W'(kend_raw);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_w       <= '0;
      clr_report  <= 1'b0;
      free_count  <= '0;
      total_count <= '0;
      search_hint <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= bpfa_pkg::kind_t'(kind);
            req_base  <= region_base;
            req_len   <= region_length;
            req_avail <= region_available;
            req_page  <= page_addr;
            if (bpfa_pkg::kind_t'(kind) == bpfa_pkg::KIND_CLEAR) begin
              clr_w      <= '0;
              clr_report <= 1'b1;
              state      <= S_CLR;
            end else begin
              state <= S_PREP;
            end
          end
        end

        S_PREP: begin
          first_pass <= 1'b1;
          case (op)
            bpfa_pkg::KIND_REGION: begin
              rng_lo <= reg_sf;
              rng_hi <= reg_ef;
              rng_ok <= req_avail && end_above;
            end
            bpfa_pkg::KIND_ALLOC: begin
              rng_lo <= RW'(search_hint);
              rng_hi <= FC_R;
              rng_ok <= (free_count != '0);
            end
            default: begin
              rng_lo <= RW'(free_f);
              rng_hi <= RW'(free_f) + RW'(1);
              rng_ok <= free_ok;
            end
          endcase
          state <= S_RANGE;
        end

        S_RANGE: begin
          res_addr <= '0;
          if (rng_ok && (rng_lo < rng_hi)) begin
            cur_lo <= HINT_W'(rng_lo);
            cur_hi <= HINT_W'(rng_hi);
            state  <= S_DIVQ;
          end else if (op == bpfa_pkg::KIND_ALLOC && rng_ok && first_pass) begin
            // wrap: second pass from kernel end up to the old hint
            first_pass <= 1'b0;
            rng_lo     <= RW'(kend_frame);
            rng_hi     <= RW'(search_hint);
          end else begin
            case (op)
              bpfa_pkg::KIND_ALLOC: res_status <= bpfa_pkg::STATUS_NO_FRAME;
              bpfa_pkg::KIND_FREE:  res_status <= bpfa_pkg::STATUS_IGNORED;
              default:              res_status <= bpfa_pkg::STATUS_DONE;
            endcase
            state <= S_FIN;
          end
        end

        S_DIVQ: begin
          cur_w <= AW'(div_prod >> SHIFT);
          state <= S_DIVB;
        end

        S_DIVB: begin
          cur_base <= word_base;
          state    <= S_READ;
        end

        S_READ: begin
          lo_off <= (cur_lo > cur_base) ? OFF_W'(cur_lo - cur_base) : '0;
          hi_off <= (diff_hi > WB_F) ? WB_O : (OFF_W+1)'(diff_hi);
          more   <= (diff_hi > WB_F);
          state  <= S_EVAL;
        end

        S_EVAL: begin
          case (op)
            bpfa_pkg::KIND_REGION: begin
              free_count  <= free_count + hit_cnt;
              total_count <= (total_sum > (bpfa_pkg::COUNT_W+1)'(bpfa_pkg::COUNT_MAX)) ?
                             bpfa_pkg::COUNT_MAX : bpfa_pkg::COUNT_W'(total_sum);
              res_status  <= bpfa_pkg::STATUS_DONE;
            end
            bpfa_pkg::KIND_ALLOC: begin
              if (cand != '0) begin
                free_count  <= free_count - CNT_W'(1);
                search_hint <= found_frame + HINT_W'(1);
                res_addr    <= bpfa_pkg::ADDR_W'(found_frame) << bpfa_pkg::PAGE_SHIFT;
                res_status  <= bpfa_pkg::STATUS_DONE;
              end else begin
                res_status  <= bpfa_pkg::STATUS_NO_FRAME;
              end
            end
            default: begin
              if (hit != '0) begin
                free_count <= free_count + CNT_W'(1);
                if (cur_lo < search_hint) begin
                  search_hint <= cur_lo;
                end
                res_status <= bpfa_pkg::STATUS_DONE;
              end else begin
                res_status <= bpfa_pkg::STATUS_IGNORED;
              end
            end
          endcase

          if (eval_take || op == bpfa_pkg::KIND_FREE) begin
            state <= S_FIN;
          end else if (more) begin
            cur_w    <= cur_w + AW'(1);
            cur_base <= cur_base + WB_F;
            state    <= S_READ;
          end else if (op == bpfa_pkg::KIND_ALLOC && first_pass) begin
            first_pass <= 1'b0;
            rng_lo     <= RW'(kend_frame);
            rng_hi     <= RW'(search_hint);
            state      <= S_RANGE;
          end else begin
            state <= S_FIN;
          end
        end

        S_CLR: begin
          clr_w <= clr_w + AW'(1);
          if (clr_w == LAST_W) begin
            if (clr_report) begin
              free_count  <= '0;
              total_count <= '0;
              search_hint <= kend_frame;
              res_status  <= bpfa_pkg::STATUS_DONE;
              res_addr    <= '0;
              state       <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            alloc_addr  <= res_addr;
            free_pages  <= bpfa_pkg::COUNT_W'(free_count);
            total_pages <= total_count;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // word walker never leaves the bitmap
  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (32'(cur_w) < WORD_COUNT))
    else $error("bitmap word index out of range");

  // free count stays within the frame range
  assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= FRAME_COUNT)
    else $error("free count above frame count");

  // hint never exceeds FRAME_COUNT
  assert property (@(posedge clk) disable iff (rst)
    32'(search_hint) <= FRAME_COUNT)
    else $error("search hint out of range");

  // a successful allocation takes exactly one frame
  assert property (@(posedge clk) disable iff (rst)
    eval_take |=> (free_count == CNT_W'($past(free_count) - CNT_W'(1))))
    else $error("allocation did not decrement free count");

endmodule
